// ===== rtl/mlus_pkg.sv =====
// Shared types, constants and codes for the multi-list unique set block.
package mlus_pkg;

  localparam int unsigned LISTEN_DEPTH_DEF = 16;
  localparam int unsigned LIST_DEPTH_DEF   = 64;
  localparam int unsigned NUM_LISTS        = 5;

  localparam int unsigned ACTION_W = 1;
  localparam int unsigned SEL_W    = 3;
  localparam int unsigned VALUE_W  = 16;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned COUNT_W  = 7;

  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 16;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ADD    = 1'b0,
    ACT_DELETE = 1'b1
  } action_e;

  typedef enum logic [SEL_W-1:0] {
    LIST_LISTEN  = 3'd0,
    LIST_READ    = 3'd1,
    LIST_PARSE   = 3'd2,
    LIST_PACKAGE = 3'd3,
    LIST_WRITE   = 3'd4
  } list_sel_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED     = 3'd0,
    ST_PRESENT   = 3'd1,
    ST_FULL      = 3'd2,
    ST_REMOVED   = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // capture the input transfer
    logic rd;     // read the entry at the scan index
    logic chk;    // compare the read entry and advance
    logic fin;    // commit the list update and load the result
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_end;  // scan index has reached the list count
    logic stop;      // add found a duplicate in the entry just read
    logic out_free;  // result register can take a new result
  } dp_sts_t;

endpackage

// ===== rtl/mlus_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mlus_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 272
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/mlus_ctrl.sv =====
// Sequencing state machine: accept, scan the list entry by entry, commit.
module mlus_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  mlus_pkg::dp_sts_t sts_i,
  output mlus_pkg::dp_cmd_t cmd_o
);
  import mlus_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_READ   = 4'b0010,
    S_CHECK  = 4'b0100,
    S_FINISH = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_READ;
        end
      end
      S_READ: begin
        if (sts_i.scan_end) begin
          state_d = S_FINISH;
        end else begin
          cmd_o.rd = 1'b1;
          state_d  = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd_o.chk = 1'b1;
        state_d   = sts_i.stop ? S_FINISH : S_READ;
      end
      S_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.fin = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CHECK |-> $past(state_q == S_READ))
    else $error("compare step without a preceding read");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.fin |-> sts_i.out_free)
    else $error("result committed while the output register is occupied");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ && sts_i.scan_end) |=> state_q == S_FINISH)
    else $error("scan end did not lead to the commit step");
`endif

endmodule

// ===== rtl/mlus_dp.sv =====
// Datapath: entry store, per-list counts, scan pointers and result register.
module mlus_dp #(
  parameter int unsigned LISTEN_DEPTH = mlus_pkg::LISTEN_DEPTH_DEF,
  parameter int unsigned LIST_DEPTH   = mlus_pkg::LIST_DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [mlus_pkg::ACTION_W-1:0]   action_i,
  input  logic [mlus_pkg::SEL_W-1:0]      list_select_i,
  input  logic [mlus_pkg::VALUE_W-1:0]    item_value_i,
  input  mlus_pkg::dp_cmd_t               cmd_i,
  output mlus_pkg::dp_sts_t               sts_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [mlus_pkg::STATUS_W-1:0]   status_o,
  output logic [mlus_pkg::COUNT_W-1:0]    list_count_o
);
  import mlus_pkg::*;

  localparam int unsigned STORE_DEPTH = LISTEN_DEPTH + 4 * LIST_DEPTH;
  localparam int unsigned AW          = $clog2(STORE_DEPTH);
  localparam int unsigned MAX_DEPTH   = (LISTEN_DEPTH > LIST_DEPTH) ? LISTEN_DEPTH : LIST_DEPTH;
  localparam int unsigned CW          = $clog2(MAX_DEPTH + 1);

  logic [CW-1:0]       cnt_q [NUM_LISTS];
  logic                act_q;
  logic [SEL_W-1:0]    sel_q;
  logic                sel_ok_q;
  logic [VALUE_W-1:0]  val_q;
  logic [AW-1:0]       base_q;
  logic [CW-1:0]       cap_q;
  logic [CW-1:0]       len_q;
  logic [CW-1:0]       idx_q;
  logic [CW-1:0]       kept_q;
  logic                found_q;
  logic                out_valid_q;
  logic [STATUS_W-1:0] status_q;
  logic [COUNT_W-1:0]  count_q;

  logic [AW-1:0]       base_d;
  logic [CW-1:0]       cap_d;
  logic [CW-1:0]       len_d;
  logic                sel_ok_d;
  logic [VALUE_W-1:0]  rd_data;
  logic                hit;
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [VALUE_W-1:0]  ram_wdata;
  status_e             res_status;
  logic [CW-1:0]       res_count;
  logic                res_upd;
  logic [CW+COUNT_W-1:0] count_ext;

  // Region base, capacity and current length of the list named by the input.
  always_comb begin
    sel_ok_d = 1'b1;
    base_d   = '0;
    cap_d    = CW'(LIST_DEPTH);
    len_d    = '0;
    unique case (list_select_i)
      LIST_LISTEN: begin
        cap_d = CW'(LISTEN_DEPTH);
        len_d = cnt_q[0];
      end
      LIST_READ: begin
        base_d = AW'(LISTEN_DEPTH);
        len_d  = cnt_q[1];
      end
      LIST_PARSE: begin
        base_d = AW'(LISTEN_DEPTH + LIST_DEPTH);
        len_d  = cnt_q[2];
      end
      LIST_PACKAGE: begin
        base_d = AW'(LISTEN_DEPTH + 2 * LIST_DEPTH);
        len_d  = cnt_q[3];
      end
      LIST_WRITE: begin
        base_d = AW'(LISTEN_DEPTH + 3 * LIST_DEPTH);
        len_d  = cnt_q[4];
      end
      default: begin
        sel_ok_d = 1'b0;
        cap_d    = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q    <= action_i;
      sel_q    <= list_select_i;
      sel_ok_q <= sel_ok_d;
      val_q    <= item_value_i;
      base_q   <= base_d;
      cap_q    <= cap_d;
      len_q    <= len_d;
    end
  end

  mlus_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.rd),
    .raddr_i (base_q + AW'(idx_q)),
    .rdata_o (rd_data)
  );

  assign hit = (rd_data == val_q);

  // Delete copies each surviving entry down to the kept position; add appends.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = base_q + AW'(kept_q);
    ram_wdata = rd_data;
    if (cmd_i.chk && act_q == ACT_DELETE && !hit) begin
      ram_we = 1'b1;
    end else if (cmd_i.fin && res_status == ST_ADDED) begin
      ram_we    = 1'b1;
      ram_waddr = base_q + AW'(len_q);
      ram_wdata = val_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      kept_q  <= '0;
      found_q <= 1'b0;
    end else if (cmd_i.load) begin
      idx_q   <= '0;
      kept_q  <= '0;
      found_q <= 1'b0;
    end else if (cmd_i.chk) begin
      idx_q <= idx_q + 1'b1;
      if (act_q == ACT_ADD && hit) begin
        found_q <= 1'b1;
      end
      if (act_q == ACT_DELETE && !hit) begin
        kept_q <= kept_q + 1'b1;
      end
    end
  end

  always_comb begin
    res_upd    = sel_ok_q;
    res_count  = len_q;
    res_status = ST_NOT_FOUND;
    if (!sel_ok_q) begin
      res_count  = '0;
      res_status = (act_q == ACT_ADD) ? ST_FULL : ST_NOT_FOUND;
    end else if (act_q == ACT_ADD) begin
      if (found_q) begin
        res_status = ST_PRESENT;
      end else if (len_q >= cap_q) begin
        res_status = ST_FULL;
      end else begin
        res_status = ST_ADDED;
        res_count  = len_q + 1'b1;
      end
    end else begin
      res_count  = kept_q;
      res_status = (kept_q < len_q) ? ST_REMOVED : ST_NOT_FOUND;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_LISTS; k++) begin
        cnt_q[k] <= '0;
      end
    end else if (cmd_i.fin && res_upd) begin
      unique case (sel_q)
        LIST_LISTEN:  cnt_q[0] <= res_count;
        LIST_READ:    cnt_q[1] <= res_count;
        LIST_PARSE:   cnt_q[2] <= res_count;
        LIST_PACKAGE: cnt_q[3] <= res_count;
        LIST_WRITE:   cnt_q[4] <= res_count;
        default: ;
      endcase
    end
  end

  assign count_ext = (CW + COUNT_W)'(res_count);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.fin) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin) begin
      status_q <= res_status;
      count_q  <= count_ext[COUNT_W-1:0];
    end
  end

  assign sts_o.scan_end = (idx_q == len_q);
  assign sts_o.stop     = (act_q == ACT_ADD) && hit;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign list_count_o = count_q;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q[0] <= CW'(LISTEN_DEPTH) && cnt_q[1] <= CW'(LIST_DEPTH) &&
    cnt_q[2] <= CW'(LIST_DEPTH) && cnt_q[3] <= CW'(LIST_DEPTH) &&
    cnt_q[4] <= CW'(LIST_DEPTH))
    else $error("list count beyond its capacity");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_i.fin))
    else $error("result presented without a commit");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    kept_q <= idx_q)
    else $error("compaction write pointer ahead of the scan pointer");
`endif

endmodule

// ===== rtl/multi_list_unique_set.sv =====
// Top level of the five-list unique value set with add and compacting delete.
// Each accepted item is handled in turn: its list is scanned entry by entry, each entry
// read and then compared, and an add that meets its duplicate stops the scan early.
// The commit waits until the result register is free. One item is taken at a time;
// the pace of the scan is set by the single read port of the entry store.
// Reset clears all list counts at once; the entry store is not cleared.
module multi_list_unique_set #(
  parameter int unsigned LISTEN_DEPTH = mlus_pkg::LISTEN_DEPTH_DEF,
  parameter int unsigned LIST_DEPTH   = mlus_pkg::LIST_DEPTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // action [0], list_select [3:1], item_value [19:4], zero [23:20]
  input  logic [mlus_pkg::IN_TDATA_W-1:0]    s_axis_tdata_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // status [2:0], list_count [9:3], zero [15:10]
  output logic [mlus_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_o
);
  import mlus_pkg::*;

  dp_cmd_t             cmd;
  dp_sts_t             sts;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0]  list_count;

  mlus_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mlus_dp #(
    .LISTEN_DEPTH (LISTEN_DEPTH),
    .LIST_DEPTH   (LIST_DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .action_i      (s_axis_tdata_i[0]),
    .list_select_i (s_axis_tdata_i[3:1]),
    .item_value_i  (s_axis_tdata_i[19:4]),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .status_o      (status),
    .list_count_o  (list_count)
  );

  assign m_axis_tdata_o = {(OUT_TDATA_W - STATUS_W - COUNT_W)'(0), list_count, status};

endmodule
